>>> rtl/fccs_pkg.sv
// ----------------------------------------------------------------------------
// fccs_pkg
// Shared types and constants of the flash channel chip scheduler.
// ----------------------------------------------------------------------------
package fccs_pkg;

  localparam int NUM_CHIPS   = 8;
  localparam int QUEUE_DEPTH = 16;
  localparam int TAG_WIDTH   = 16;
  localparam int CHIP_W      = 3;
  localparam int SLOT_W      = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int LIM_W       = 5;
  localparam int CIDX_W      = $clog2(NUM_CHIPS);
  localparam int CIDX_CNT_W  = $clog2(NUM_CHIPS + 1);
  localparam int ENTRY_W     = 2 + TAG_WIDTH;
  localparam int CMDQ_DEPTH  = 4;
  localparam int CMDQ_AW     = 2;

  localparam logic [1:0] CFG_READ_LAT  = 2'd0;
  localparam logic [1:0] CFG_PROG_LAT  = 2'd1;
  localparam logic [1:0] CFG_ERASE_LAT = 2'd2;
  localparam logic [1:0] CFG_QLIMIT    = 2'd3;

  localparam logic OPC_ENQUEUE = 1'b0;
  localparam logic OPC_TICK    = 1'b1;

  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_PROG  = 2'd1;
  localparam logic [1:0] OP_ERASE = 2'd2;

  localparam logic [1:0] EV_ACCEPTED  = 2'd0;
  localparam logic [1:0] EV_REJECTED  = 2'd1;
  localparam logic [1:0] EV_STARTED   = 2'd2;
  localparam logic [1:0] EV_COMPLETED = 2'd3;

  typedef struct packed {
    logic                 opcode;
    logic [CHIP_W-1:0]    chip;
    logic [1:0]           op;
    logic [TAG_WIDTH-1:0] tag;
  } cmd_t;

  typedef struct packed {
    logic [1:0]           kind;
    logic [CHIP_W-1:0]    chip;
    logic [1:0]           op;
    logic [TAG_WIDTH-1:0] tag;
    logic                 last;
  } event_t;

endpackage

>>> rtl/fccs_cmd_queue.sv
// ----------------------------------------------------------------------------
// fccs_cmd_queue
// Short command queue between the front end and the scheduling engine.
// ----------------------------------------------------------------------------
module fccs_cmd_queue import fccs_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output cmd_t pop_data,
  output logic empty
);
  cmd_t                mem_r [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0]  wr_r, rd_r;
  logic [CMDQ_AW:0]    cnt_r;

  assign full     = (cnt_r == (CMDQ_AW+1)'(CMDQ_DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem_r[wr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push && !full) wr_r <= wr_r + 1'b1;
      if (pop && !empty) rd_r <= rd_r + 1'b1;
      cnt_r <= cnt_r + (CMDQ_AW+1)'(push && !full) - (CMDQ_AW+1)'(pop && !empty);
    end
  end
endmodule

>>> rtl/fccs_engine.sv
// ----------------------------------------------------------------------------
// fccs_engine
// Back end: runs enqueues and ticks over per-chip FIFOs, one event at a time.
// ----------------------------------------------------------------------------
module fccs_engine import fccs_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cmd_valid,
  input  cmd_t             cmd,
  output logic             cmd_pop,
  input  logic [15:0]      read_lat,
  input  logic [15:0]      prog_lat,
  input  logic [15:0]      erase_lat,
  input  logic [LIM_W-1:0] qlimit,
  output logic             ev_valid,
  output event_t           ev,
  input  logic             ev_ready
);
  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_ENQ   = 5'b00010,
    S_DONE  = 5'b00100,
    S_READ  = 5'b01000,
    S_START = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic [ENTRY_W-1:0] store_r [NUM_CHIPS*QUEUE_DEPTH];
  logic [ENTRY_W-1:0] rd_data_r;
  logic [SLOT_W-1:0]  head_r [NUM_CHIPS];
  logic [SLOT_W-1:0]  tail_r [NUM_CHIPS];
  logic [CNT_W-1:0]   count_r [NUM_CHIPS];
  logic               busy_r [NUM_CHIPS];
  logic [31:0]        wake_r [NUM_CHIPS];
  logic [ENTRY_W-1:0] run_r [NUM_CHIPS];
  logic [31:0]        now_r;
  logic [CIDX_CNT_W-1:0] idx_r;
  cmd_t               cmd_r;
  logic               ev_valid_r;
  event_t             ev_r;

  logic [CNT_W-1:0]   lim;
  logic [CIDX_W-1:0]  ci;
  logic               due_v [NUM_CHIPS];
  logic               due, has_next_start, later_event;
  logic [1:0]         rop;
  logic [15:0]        rlat;
  logic               enq_ok;

  always_comb begin
    if (qlimit == '0) lim = CNT_W'(1);
    else if (CNT_W'(qlimit) > CNT_W'(QUEUE_DEPTH)) lim = CNT_W'(QUEUE_DEPTH);
    else lim = CNT_W'(qlimit);
  end

  function automatic logic [SLOT_W-1:0] nxt_ptr(input logic [SLOT_W-1:0] p,
                                               input logic [CNT_W-1:0] l);
    logic [CNT_W-1:0] n;
    n = CNT_W'(p) + 1'b1;
    return (n >= l) ? '0 : SLOT_W'(n);
  endfunction

  // A chip is due once now has reached its wakeup time within half the range.
  always_comb begin
    logic [31:0] dk;
    for (int k = 0; k < NUM_CHIPS; k++) begin
      dk = now_r - wake_r[k];
      due_v[k] = busy_r[k] && !dk[31];
    end
  end

  assign ci   = idx_r[CIDX_W-1:0];
  assign due  = due_v[ci];
  assign rop  = rd_data_r[ENTRY_W-1 -: 2];
  assign enq_ok = ({1'b0, cmd_r.chip} < (CHIP_W+1)'(NUM_CHIPS)) &&
                  (count_r[cmd_r.chip[CIDX_W-1:0]] < lim);

  always_comb begin
    unique case (rop)
      OP_READ:  rlat = read_lat;
      OP_PROG:  rlat = prog_lat;
      OP_ERASE: rlat = erase_lat;
      default:  rlat = '0;
    endcase
  end

  // Does any chip after ci still start this tick? Flags last event.
  always_comb begin
    has_next_start = 1'b0;
    for (int k = 0; k < NUM_CHIPS; k++) begin
      if (k > int'(ci) && !busy_r[k] && count_r[k] != '0) has_next_start = 1'b1;
    end
  end

  // During completions: another completion follows, or some chip will start.
  always_comb begin
    later_event = 1'b0;
    for (int k = 0; k < NUM_CHIPS; k++) begin
      if (k > int'(ci) && due_v[k]) later_event = 1'b1;
      if ((!busy_r[k] || due_v[k]) && count_r[k] != '0) later_event = 1'b1;
    end
  end

  logic ev_free, ev_fire;
  assign ev_free  = !ev_valid_r || ev_ready;
  assign ev_fire  = ev_free && ((state_r == S_ENQ) || (state_r == S_START) ||
                                (state_r == S_DONE && due));
  assign ev_valid = ev_valid_r;
  assign ev       = ev_r;
  assign cmd_pop  = (state_r == S_IDLE) && cmd_valid;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (cmd_valid) state_nxt = (cmd.opcode == OPC_TICK) ? S_DONE : S_ENQ;
      S_ENQ:   if (ev_free) state_nxt = S_IDLE;
      S_DONE:  if (!due || ev_free) begin
                 if (idx_r == CIDX_CNT_W'(NUM_CHIPS - 1)) state_nxt = S_READ;
               end
      S_READ:  if (idx_r == CIDX_CNT_W'(NUM_CHIPS)) state_nxt = S_IDLE;
               else if (!busy_r[ci] && count_r[ci] != '0) state_nxt = S_START;
      S_START: if (ev_free) state_nxt = S_READ;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == S_ENQ && ev_free && enq_ok) begin
      store_r[{cmd_r.chip[CIDX_W-1:0], tail_r[cmd_r.chip[CIDX_W-1:0]]}] <=
        {cmd_r.op, cmd_r.tag};
    end
    rd_data_r <= store_r[{ci, head_r[ci]}];
    if (state_r == S_IDLE && cmd_valid) cmd_r <= cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      idx_r      <= '0;
      now_r      <= '0;
      ev_valid_r <= 1'b0;
      ev_r       <= '0;
      for (int k = 0; k < NUM_CHIPS; k++) begin
        head_r[k]  <= '0;
        tail_r[k]  <= '0;
        count_r[k] <= '0;
        busy_r[k]  <= 1'b0;
        wake_r[k]  <= '0;
        run_r[k]   <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (ev_fire) ev_valid_r <= 1'b1;
      else if (ev_ready) ev_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          idx_r <= '0;
          if (cmd_valid && cmd.opcode == OPC_TICK) now_r <= now_r + 1'b1;
        end
        S_ENQ: if (ev_free) begin
          ev_r.chip  <= cmd_r.chip;
          ev_r.op    <= cmd_r.op;
          ev_r.tag   <= cmd_r.tag;
          ev_r.last  <= 1'b1;
          if (enq_ok) begin
            ev_r.kind <= EV_ACCEPTED;
            tail_r[cmd_r.chip[CIDX_W-1:0]]  <= nxt_ptr(tail_r[cmd_r.chip[CIDX_W-1:0]], lim);
            count_r[cmd_r.chip[CIDX_W-1:0]] <= count_r[cmd_r.chip[CIDX_W-1:0]] + 1'b1;
          end else begin
            ev_r.kind <= EV_REJECTED;
          end
        end
        S_DONE: if (!due || ev_free) begin
          if (due) begin
            ev_r.kind  <= EV_COMPLETED;
            ev_r.chip  <= CHIP_W'(ci);
            ev_r.op    <= run_r[ci][ENTRY_W-1 -: 2];
            ev_r.tag   <= run_r[ci][TAG_WIDTH-1:0];
            ev_r.last  <= !later_event;
            busy_r[ci] <= 1'b0;
            wake_r[ci] <= '0;
            run_r[ci]  <= '0;
          end
          idx_r <= (idx_r == CIDX_CNT_W'(NUM_CHIPS - 1)) ? '0 : idx_r + 1'b1;
        end
        S_READ: begin
          if (idx_r != CIDX_CNT_W'(NUM_CHIPS) && (busy_r[ci] || count_r[ci] == '0)) begin
            idx_r <= idx_r + 1'b1;
          end
        end
        S_START: if (ev_free) begin
          ev_r.kind  <= EV_STARTED;
          ev_r.chip  <= CHIP_W'(ci);
          ev_r.op    <= rop;
          ev_r.tag   <= rd_data_r[TAG_WIDTH-1:0];
          ev_r.last  <= !has_next_start;
          head_r[ci]  <= nxt_ptr(head_r[ci], lim);
          count_r[ci] <= count_r[ci] - 1'b1;
          busy_r[ci]  <= 1'b1;
          run_r[ci]   <= rd_data_r;
          wake_r[ci]  <= now_r + 32'(rlat);
          idx_r       <= idx_r + 1'b1;
        end
        default: ;
      endcase
    end
  end
endmodule

>>> rtl/fccs_event_buf.sv
// ----------------------------------------------------------------------------
// fccs_event_buf
// Result queue holding events until the consumer pops them.
// ----------------------------------------------------------------------------
module fccs_event_buf import fccs_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   wr_valid,
  input  event_t wr_data,
  output logic   wr_ready,
  input  logic   pop,
  output event_t rd_data,
  output logic   empty
);
  // Two-entry buffer.
  event_t          mem_r [2];
  logic            wr_r, rd_r;
  logic [1:0]      cnt_r;

  assign wr_ready = (cnt_r != 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign rd_data  = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (wr_valid && wr_ready) mem_r[wr_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (wr_valid && wr_ready) wr_r <= !wr_r;
      if (pop && !empty) rd_r <= !rd_r;
      cnt_r <= cnt_r + 2'(wr_valid && wr_ready) - 2'(pop && !empty);
    end
  end
endmodule

>>> rtl/flash_channel_chip_scheduler_unit.sv
// ----------------------------------------------------------------------------
// flash_channel_chip_scheduler_unit
// Per-chip operation FIFOs with a microsecond tick that completes and starts
// flash operations on one channel.
// An enqueue is answered with one event. The engine takes a queued command
// only once the last one is done; a tick scans the chips serially, and a full
// event buffer can stall both.
// Reset: synchronous active-low; all FIFOs empty, all chips idle, time zero.
// ----------------------------------------------------------------------------
module flash_channel_chip_scheduler_unit import fccs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  output logic                 full,
  input  logic                 in_opcode,
  input  logic [CHIP_W-1:0]    in_chip_index,
  input  logic [1:0]           in_op_kind,
  input  logic [TAG_WIDTH-1:0] in_request_tag,
  output logic                 empty,
  input  logic                 pop,
  output logic [1:0]           out_event_kind,
  output logic [CHIP_W-1:0]    out_event_chip,
  output logic [1:0]           out_event_op,
  output logic [TAG_WIDTH-1:0] out_event_tag,
  output logic                 out_is_last,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [15:0]          cfg_data
);
  logic [15:0]      read_lat_r, prog_lat_r, erase_lat_r;
  logic [LIM_W-1:0] qlimit_r;

  // Configuration registers; always ready.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      read_lat_r  <= 16'd50;
      prog_lat_r  <= 16'd500;
      erase_lat_r <= 16'd3000;
      qlimit_r    <= LIM_W'(QUEUE_DEPTH);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_READ_LAT:  read_lat_r  <= cfg_data;
        CFG_PROG_LAT:  prog_lat_r  <= cfg_data;
        CFG_ERASE_LAT: erase_lat_r <= cfg_data;
        CFG_QLIMIT:    qlimit_r    <= cfg_data[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Front: accept transactions into a short command queue.
  cmd_t in_cmd, q_cmd;
  logic q_empty, q_pop;
  assign in_cmd = '{opcode: in_opcode, chip: in_chip_index, op: in_op_kind,
                    tag: in_request_tag};

  fccs_cmd_queue u_cmdq (
    .clk, .rst_n,
    .push(push), .push_data(in_cmd), .full(full),
    .pop(q_pop), .pop_data(q_cmd), .empty(q_empty)
  );

  // Back: scheduling engine, then the event buffer.
  logic   ev_valid, ev_ready;
  event_t ev, buf_ev;

  fccs_engine u_eng (
    .clk, .rst_n,
    .cmd_valid(!q_empty), .cmd(q_cmd), .cmd_pop(q_pop),
    .read_lat(read_lat_r), .prog_lat(prog_lat_r), .erase_lat(erase_lat_r),
    .qlimit(qlimit_r),
    .ev_valid(ev_valid), .ev(ev), .ev_ready(ev_ready)
  );

  // Hold engine events here until the consumer pops them.
  fccs_event_buf u_evbuf (
    .clk, .rst_n,
    .wr_valid(ev_valid), .wr_data(ev), .wr_ready(ev_ready),
    .pop(pop), .rd_data(buf_ev), .empty(empty)
  );

  assign out_event_kind = buf_ev.kind;
  assign out_event_chip = buf_ev.chip;
  assign out_event_op   = buf_ev.op;
  assign out_event_tag  = buf_ev.tag;
  assign out_is_last    = buf_ev.last;
endmodule
